@@ hdl/ackt_pkg.sv @@
`default_nettype none
package ackt_pkg;

    localparam int CMD_FIFO_DEPTH = 2;
    localparam int RES_FIFO_DEPTH = 4;
    localparam int MAX_RESULTS    = 16;

    typedef enum logic [2:0] {
        OP_ENQUEUE = 3'd0,
        OP_INFO    = 3'd1,
        OP_ACK     = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_EXPIRE  = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_QUEUED      = 4'd0,
        ST_DROPPED     = 4'd1,
        ST_ATTACHED    = 4'd2,
        ST_INFO_NO_UE  = 4'd3,
        ST_INFO_NO_PKT = 4'd4,
        ST_ACK_REPORT  = 4'd5,
        ST_ACK_NONE    = 4'd6,
        ST_REMOVED     = 4'd7,
        ST_REMOVE_NONE = 4'd8,
        ST_EXPIRED     = 4'd9,
        ST_TABLE_FULL  = 4'd10
    } status_t;

    typedef struct packed {
        op_t          op;
        logic         slot_ok;
        logic [3:0]   ue;
        logic [17:0]  psn;
        logic [31:0]  fid;
        logic         mark;
        logic [17:0]  rsn;
        logic [3:0]   lk;
        logic [47:0]  t;
        logic [31:0]  now;
    } cmd_t;

    typedef struct packed {
        logic [3:0]   status;
        logic [3:0]   ue;
        logic [17:0]  psn;
        logic [31:0]  frame;
        logic [3:0]   lk;
        logic [47:0]  delay;
        logic         pdone;
        logic         fdone;
        logic [4:0]   rc;
        logic         last;
    } res_t;

    typedef struct packed {
        logic [17:0]  sn;
        logic [31:0]  frame;
        logic         marker;
    } hdr_t;

    typedef struct packed {
        logic         v;
        logic [17:0]  num;
        logic [47:0]  tm;
    } seg_t;

endpackage
`default_nettype wire

@@ hdl/ackt_ram.sv @@
`default_nettype none
module ackt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

@@ hdl/ackt_fifo.sv @@
`default_nettype none
module ackt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/ackt_front.sv @@
`default_nettype none
module ackt_front #(
    parameter int NUM_USERS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [2:0]      command,
    input  wire logic [3:0]      ue_index,
    input  wire logic [17:0]     pdcp_sn,
    input  wire logic [31:0]     frame_num,
    input  wire logic            last_of_frame,
    input  wire logic [17:0]     rlc_sn,
    input  wire logic [3:0]      link_id,
    input  wire logic [47:0]     time_us,
    input  wire logic [31:0]     now_seconds,
    input  wire logic            cmd_pop,
    output ackt_pkg::cmd_t       cmd_head,
    output logic                 cmd_empty
);

    ackt_pkg::cmd_t cmd_in;
    logic           known;
    logic           fifo_push;
    logic [$bits(ackt_pkg::cmd_t)-1:0] head_bits;

    always_comb
    begin
        known           = command inside {[3'd0:3'd4]};
        cmd_in.op       = ackt_pkg::op_t'(command);
        cmd_in.slot_ok  = (9'(ue_index) < 9'(NUM_USERS));
        cmd_in.ue       = ue_index;
        cmd_in.psn      = pdcp_sn;
        cmd_in.fid      = frame_num;
        cmd_in.mark     = last_of_frame;
        cmd_in.rsn      = rlc_sn;
        cmd_in.lk       = link_id;
        cmd_in.t        = time_us;
        cmd_in.now      = now_seconds;
    end

    // unknown codes are taken and dropped here
    assign fifo_push = push && known;
    assign cmd_head  = ackt_pkg::cmd_t'(head_bits);

    ackt_fifo #(
        .WIDTH($bits(ackt_pkg::cmd_t)),
        .DEPTH(ackt_pkg::CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (head_bits),
        .empty (cmd_empty)
    );

endmodule
`default_nettype wire

@@ hdl/ackt_engine.sv @@
`default_nettype none
module ackt_engine #(
    parameter int NUM_USERS           = 16,
    parameter int QUEUE_DEPTH         = 16,
    parameter int SEGMENTS_PER_PACKET = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [15:0]     timeout,
    input  wire ackt_pkg::cmd_t  cmd_head,
    input  wire logic            cmd_empty,
    output logic                 cmd_pop,
    input  wire logic            out_full,
    output logic                 out_push,
    output ackt_pkg::res_t       out_data
);

    localparam int DEPTH = NUM_USERS * QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int UW    = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
    localparam int LW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SIW   = (SEGMENTS_PER_PACKET > 1) ? $clog2(SEGMENTS_PER_PACKET) : 1;
    localparam int HW    = $bits(ackt_pkg::hdr_t);
    localparam int SGW   = $bits(ackt_pkg::seg_t) * SEGMENTS_PER_PACKET;
    localparam int RW    = HW + SGW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_INFO_RD,
        S_INFO_CHK,
        S_ACK_RD,
        S_ACK_CHK,
        S_CP_RD,
        S_CP_WR,
        S_ACK_END,
        S_EXP,
        S_EXP_END,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    ackt_pkg::cmd_t          cur_reg;
    ackt_pkg::res_t          res_reg;
    logic [NUM_USERS-1:0]    active_reg;
    logic [LW-1:0]           qlen_reg [NUM_USERS];
    logic [31:0]             last_act_reg [NUM_USERS];
    logic [LW-1:0]           idx_reg;
    logic [LW-1:0]           cp_reg;
    logic [4:0]              n_reg;
    logic                    pend_reg;
    logic [4:0]              cnt_reg;
    logic [UW-1:0]           uscan_reg;
    logic [AW-1:0]           rd_addr_reg;

    logic [UW-1:0]           ui;
    logic                    act;
    logic [LW-1:0]           len;
    logic [LW-1:0]           len_eff;
    logic                    enq_room;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [RW-1:0]           ram_wdata;
    logic [RW-1:0]           ram_rdata;
    ackt_pkg::hdr_t          hdr_rd;
    ackt_pkg::hdr_t          hdr_new;
    ackt_pkg::seg_t [SEGMENTS_PER_PACKET-1:0] segs_rd;
    ackt_pkg::seg_t [SEGMENTS_PER_PACKET-1:0] segs_info;
    ackt_pkg::seg_t [SEGMENTS_PER_PACKET-1:0] segs_ack;
    logic [SEGMENTS_PER_PACKET-1:0] vld;
    logic                    num_hit;
    logic [SIW-1:0]          hit_idx;
    logic                    free_ok;
    logic [SIW-1:0]          free_idx;
    logic [SIW-1:0]          info_slot;
    logic                    sn_match;
    logic                    pkt_done;
    logic [47:0]             delay;
    logic                    n_room;
    logic                    stall;
    logic                    exp_hit;
    ackt_pkg::res_t          res_base;

    function automatic logic [AW-1:0] row_addr(input logic [UW-1:0] u, input logic [LW-1:0] k);
        return AW'(32'(u) * 32'(QUEUE_DEPTH) + 32'(k));
    endfunction

    assign ui       = UW'(cur_reg.ue);
    assign act      = cur_reg.slot_ok && active_reg[ui];
    assign len      = qlen_reg[ui];
    assign len_eff  = act ? len : '0;
    assign enq_room = (len_eff < LW'(QUEUE_DEPTH));
    assign hdr_rd   = ram_rdata[RW-1 -: HW];
    assign segs_rd  = ram_rdata[SGW-1:0];
    assign sn_match = (hdr_rd.sn == cur_reg.psn);
    assign n_room   = (n_reg < 5'(ackt_pkg::MAX_RESULTS));
    assign stall    = num_hit && n_room && pend_reg && out_full;
    assign cmd_pop  = (state_reg == S_IDLE) && !cmd_empty;
    assign out_data = res_reg;

    always_comb
    begin
        hdr_new.sn     = cur_reg.psn;
        hdr_new.frame  = cur_reg.fid;
        hdr_new.marker = cur_reg.mark;
    end

    // lowest matching segment and lowest free slot
    always_comb
    begin
        num_hit  = 1'b0;
        hit_idx  = '0;
        free_ok  = 1'b0;
        free_idx = '0;
        for (int s = SEGMENTS_PER_PACKET - 1; s >= 0; s--)
        begin
            vld[s] = segs_rd[s].v;
            if (segs_rd[s].v && (segs_rd[s].num == cur_reg.rsn))
            begin
                num_hit = 1'b1;
                hit_idx = SIW'(s);
            end
            if (!segs_rd[s].v)
            begin
                free_ok  = 1'b1;
                free_idx = SIW'(s);
            end
        end
    end

    always_comb
    begin
        info_slot = num_hit ? hit_idx : free_idx;
        segs_info = segs_rd;
        segs_info[info_slot].v   = 1'b1;
        segs_info[info_slot].num = cur_reg.rsn;
        segs_info[info_slot].tm  = cur_reg.t;
        segs_ack  = segs_rd;
        segs_ack[hit_idx].v = 1'b0;
        pkt_done  = ($countones(vld) == 1);
        delay     = cur_reg.t - segs_rd[hit_idx].tm;
    end

    assign exp_hit = active_reg[uscan_reg]
                     && ((cur_reg.now - last_act_reg[uscan_reg]) > 32'(timeout));

    always_comb
    begin
        res_base        = '0;
        res_base.ue     = cur_reg.ue;
        res_base.last   = 1'b1;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = rd_addr_reg;
        ram_raddr = rd_addr_reg;
        ram_wdata = ram_rdata;
        out_push  = 1'b0;
        case (state_reg)
            S_DISP:
            begin
                if (cur_reg.op == ackt_pkg::OP_ENQUEUE && cur_reg.slot_ok && enq_room)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = row_addr(ui, len_eff);
                    ram_wdata = {hdr_new, SGW'(0)};
                end
            end
            S_INFO_RD:
            begin
                ram_raddr = row_addr(ui, idx_reg);
            end
            S_INFO_CHK:
            begin
                if (sn_match && (num_hit || free_ok))
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {hdr_rd, segs_info};
                end
            end
            S_ACK_RD:
            begin
                ram_raddr = row_addr(ui, idx_reg);
            end
            S_ACK_CHK:
            begin
                if (num_hit && !stall && !pkt_done)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {hdr_rd, segs_ack};
                end
                out_push = num_hit && n_room && pend_reg && !out_full;
            end
            S_CP_RD:
            begin
                ram_raddr = row_addr(ui, cp_reg + LW'(1));
            end
            S_CP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = row_addr(ui, cp_reg);
            end
            S_EMIT:
            begin
                out_push = !out_full;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DISP && cur_reg.op == ackt_pkg::OP_ENQUEUE && cur_reg.slot_ok
            && (!act || enq_room))
        begin
            last_act_reg[ui] <= cur_reg.now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cur_reg     <= '0;
            res_reg     <= '0;
            active_reg  <= '0;
            for (int u = 0; u < NUM_USERS; u++)
            begin
                qlen_reg[u] <= '0;
            end
            idx_reg     <= '0;
            cp_reg      <= '0;
            n_reg       <= '0;
            pend_reg    <= 1'b0;
            cnt_reg     <= '0;
            uscan_reg   <= '0;
            rd_addr_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        cur_reg   <= cmd_head;
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    res_reg   <= res_base;
                    idx_reg   <= '0;
                    n_reg     <= '0;
                    pend_reg  <= 1'b0;
                    cnt_reg   <= '0;
                    uscan_reg <= '0;
                    state_reg <= S_EMIT;
                    case (cur_reg.op)
                        ackt_pkg::OP_ENQUEUE:
                        begin
                            res_reg.psn <= cur_reg.psn;
                            if (!cur_reg.slot_ok)
                            begin
                                res_reg.status <= ackt_pkg::ST_DROPPED;
                            end
                            else
                            begin
                                active_reg[ui] <= 1'b1;
                                if (enq_room)
                                begin
                                    qlen_reg[ui]   <= len_eff + 1'b1;
                                    res_reg.status <= ackt_pkg::ST_QUEUED;
                                end
                                else
                                begin
                                    qlen_reg[ui]   <= len_eff;
                                    res_reg.status <= ackt_pkg::ST_DROPPED;
                                end
                            end
                        end
                        ackt_pkg::OP_INFO:
                        begin
                            res_reg.psn <= cur_reg.psn;
                            res_reg.lk  <= cur_reg.lk;
                            if (!act)
                            begin
                                res_reg.status <= ackt_pkg::ST_INFO_NO_UE;
                            end
                            else
                            begin
                                state_reg <= S_INFO_RD;
                            end
                        end
                        ackt_pkg::OP_ACK:
                        begin
                            res_reg.lk     <= cur_reg.lk;
                            res_reg.status <= ackt_pkg::ST_ACK_NONE;
                            if (act)
                            begin
                                state_reg <= S_ACK_RD;
                            end
                        end
                        ackt_pkg::OP_REMOVE:
                        begin
                            if (!act)
                            begin
                                res_reg.status <= ackt_pkg::ST_REMOVE_NONE;
                            end
                            else
                            begin
                                active_reg[ui] <= 1'b0;
                                qlen_reg[ui]   <= '0;
                                res_reg.status <= ackt_pkg::ST_REMOVED;
                            end
                        end
                        ackt_pkg::OP_EXPIRE:
                        begin
                            state_reg <= S_EXP;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_INFO_RD:
                begin
                    rd_addr_reg <= row_addr(ui, idx_reg);
                    if (idx_reg == len)
                    begin
                        res_reg.status <= ackt_pkg::ST_INFO_NO_PKT;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_INFO_CHK;
                    end
                end
                S_INFO_CHK:
                begin
                    if (sn_match)
                    begin
                        res_reg.status <= (num_hit || free_ok) ? ackt_pkg::ST_ATTACHED
                                                               : ackt_pkg::ST_TABLE_FULL;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_INFO_RD;
                    end
                end
                S_ACK_RD:
                begin
                    rd_addr_reg <= row_addr(ui, idx_reg);
                    state_reg   <= (idx_reg == len) ? S_ACK_END : S_ACK_CHK;
                end
                S_ACK_CHK:
                begin
                    if (!num_hit)
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_ACK_RD;
                    end
                    else if (!stall)
                    begin
                        if (n_room)
                        begin
                            res_reg        <= res_base;
                            res_reg.status <= ackt_pkg::ST_ACK_REPORT;
                            res_reg.psn    <= hdr_rd.sn;
                            res_reg.frame  <= pkt_done ? hdr_rd.frame : 32'd0;
                            res_reg.lk     <= cur_reg.lk;
                            res_reg.delay  <= delay;
                            res_reg.pdone  <= pkt_done;
                            res_reg.fdone  <= pkt_done && hdr_rd.marker;
                            res_reg.last   <= 1'b0;
                            pend_reg       <= 1'b1;
                            n_reg          <= n_reg + 1'b1;
                        end
                        if (pkt_done)
                        begin
                            cp_reg    <= idx_reg;
                            state_reg <= S_CP_RD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_ACK_RD;
                        end
                    end
                end
                S_CP_RD:
                begin
                    // close up the queue behind the finished packet
                    if (cp_reg + LW'(1) == len)
                    begin
                        qlen_reg[ui] <= len - 1'b1;
                        state_reg    <= S_ACK_RD;
                    end
                    else
                    begin
                        state_reg <= S_CP_WR;
                    end
                end
                S_CP_WR:
                begin
                    cp_reg    <= cp_reg + 1'b1;
                    state_reg <= S_CP_RD;
                end
                S_ACK_END:
                begin
                    if (pend_reg)
                    begin
                        res_reg.last <= 1'b1;
                    end
                    else
                    begin
                        res_reg        <= res_base;
                        res_reg.status <= ackt_pkg::ST_ACK_NONE;
                        res_reg.lk     <= cur_reg.lk;
                    end
                    state_reg <= S_EMIT;
                end
                S_EXP:
                begin
                    if (exp_hit)
                    begin
                        active_reg[uscan_reg] <= 1'b0;
                        qlen_reg[uscan_reg]   <= '0;
                        cnt_reg               <= cnt_reg + 1'b1;
                    end
                    if (uscan_reg == UW'(NUM_USERS - 1))
                    begin
                        state_reg <= S_EXP_END;
                    end
                    else
                    begin
                        uscan_reg <= uscan_reg + 1'b1;
                    end
                end
                S_EXP_END:
                begin
                    res_reg        <= res_base;
                    res_reg.status <= ackt_pkg::ST_EXPIRED;
                    res_reg.rc     <= cnt_reg;
                    state_reg      <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    ackt_ram #(
        .WIDTH(RW),
        .DEPTH(DEPTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

@@ hdl/per_ue_packet_ack_tracker_unit.sv @@
`default_nettype none
// Per-user packet acknowledgement tracker. Commands are pushed into a short
// command queue and carried out one at a time against a row memory that holds
// one packet per row (header plus its segment table); results leave through a
// result queue, and an ack may give up to 16 of them, the final one with last
// set. Info and ack walk the user's queue through the registered read of the
// row memory; an ack that completes a packet shifts every later packet up one
// row, each row read and then written back. No clearing pass follows reset.
module per_ue_packet_ack_tracker_unit #(
    parameter int NUM_USERS           = 16,
    parameter int QUEUE_DEPTH         = 16,
    parameter int SEGMENTS_PER_PACKET = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  command,
    input  wire logic [3:0]  ue_index,
    input  wire logic [17:0] pdcp_sn,
    input  wire logic [31:0] frame_num,
    input  wire logic        last_of_frame,
    input  wire logic [17:0] rlc_sn,
    input  wire logic [3:0]  link_id,
    input  wire logic [47:0] time_us,
    input  wire logic [31:0] now_seconds,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       status,
    output logic [3:0]       out_ue_index,
    output logic [17:0]      out_pdcp_sn,
    output logic [31:0]      out_frame_num,
    output logic [3:0]       out_link_id,
    output logic [47:0]      delay_us,
    output logic             packet_done,
    output logic             frame_done,
    output logic [4:0]       expired_count,
    output logic             last
);

    logic [15:0]     timeout_reg;
    ackt_pkg::cmd_t  cmd_head;
    logic            cmd_empty;
    logic            cmd_pop;
    logic            res_full;
    logic            res_push;
    ackt_pkg::res_t  res_in;
    ackt_pkg::res_t  res_out;
    logic [$bits(ackt_pkg::res_t)-1:0] res_bits;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 16'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    ackt_front #(
        .NUM_USERS(NUM_USERS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .ue_index      (ue_index),
        .pdcp_sn       (pdcp_sn),
        .frame_num     (frame_num),
        .last_of_frame (last_of_frame),
        .rlc_sn        (rlc_sn),
        .link_id       (link_id),
        .time_us       (time_us),
        .now_seconds   (now_seconds),
        .cmd_pop       (cmd_pop),
        .cmd_head      (cmd_head),
        .cmd_empty     (cmd_empty)
    );

    ackt_engine #(
        .NUM_USERS           (NUM_USERS),
        .QUEUE_DEPTH         (QUEUE_DEPTH),
        .SEGMENTS_PER_PACKET (SEGMENTS_PER_PACKET)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .timeout   (timeout_reg),
        .cmd_head  (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_full  (res_full),
        .out_push  (res_push),
        .out_data  (res_in)
    );

    ackt_fifo #(
        .WIDTH($bits(ackt_pkg::res_t)),
        .DEPTH(ackt_pkg::RES_FIFO_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign res_out       = ackt_pkg::res_t'(res_bits);
    assign status        = res_out.status;
    assign out_ue_index  = res_out.ue;
    assign out_pdcp_sn   = res_out.psn;
    assign out_frame_num = res_out.frame;
    assign out_link_id   = res_out.lk;
    assign delay_us      = res_out.delay;
    assign packet_done   = res_out.pdone;
    assign frame_done    = res_out.fdone;
    assign expired_count = res_out.rc;
    assign last          = res_out.last;

endmodule
`default_nettype wire
